### rtl/rcc_pkg.sv
// shared types, constants and datapath operation codes of the region cache
package rcc_pkg;

   localparam int SLOTS        = 8;
   localparam int SLOT_BITS    = $clog2(SLOTS);
   localparam int REGION_SHIFT = 12;
   localparam int OFFSET_BITS  = 48;
   localparam int TAG_BITS     = OFFSET_BITS - REGION_SHIFT;
   localparam int REGION_SIZE  = 1 << REGION_SHIFT;
   localparam int MAX_RESULTS  = 17;
   localparam int COUNT_BITS   = $clog2(MAX_RESULTS);

   // datapath operations selected by the control word
   localparam logic [2:0] OP_NOP    = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1;
   localparam logic [2:0] OP_TRUNC  = 3'd2;
   localparam logic [2:0] OP_MATCH  = 3'd3;
   localparam logic [2:0] OP_SWEEP  = 3'd4;
   localparam logic [2:0] OP_CHUNK  = 3'd5;
   localparam logic [2:0] OP_BEYOND = 3'd6;

   typedef struct packed {
      logic [47:0] read_offset;
      logic [15:0] read_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  slot;
      logic        hit;
      logic        evicted;
      logic [47:0] region_start;
      logic [11:0] buffer_offset;
      logic [12:0] chunk_length;
      logic [15:0] dest_offset;
      logic [15:0] total_length;
      logic        beyond_end;
      logic        last_chunk;
   } rsp_type;

   // status from the datapath that the sequencer branches on
   typedef struct packed {
      logic fire;
      logic beyond;
      logic hit;
      logic victim;
      logic out_busy;
      logic more;
   } flags_type;

   typedef struct packed {
      logic [2:0] op;
      logic       idle;
   } ctrl_type;

endpackage

### rtl/region_cache_clock_replacement.sv
// region cache with clock replacement: top level and datapath
//
// A read request item (offset, length) enters on req_valid/req_stall and is
// checked against the backing size, which the user must write through
// csr_write_enable/csr_write_data only while the block is idle; the block
// does not enforce this. The read is truncated to the file end and split at
// region boundaries; each chunk leaves as one rsp item naming the slot that
// holds its region, found by a tag match over the eight slots or loaded into
// the slot that the clock hand picks. An offset past the end gives one item
// with beyond_end set. One request is handled at a time. A chunk that hits
// passes the lookup, chunk and next steps; a miss adds a sweep step for each
// slot the clock hand visits (1 to 9), and each request adds the accept,
// truncation and closing steps. Chunks leave through one output register;
// while rsp_stall holds it full the sequencer waits on the chunk step and
// req_stall stays high. Reset clears all slots, the accessed bits, the clock
// hand, the backing size and the output valid.
module region_cache_clock_replacement
   import rcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [47:0] csr_write_data
);

   ctrl_type  ctrl;
   flags_type flags;

   logic [47:0]         backing_size_ff;
   logic [47:0]         off_ff;
   logic [15:0]         len_ff;
   logic [15:0]         dest_ff;
   logic [15:0]         total_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic                hit_ff;
   logic                evict_ff;
   logic                last_ff;
   logic [SLOT_BITS-1:0]  hand_ff;
   logic [TAG_BITS-1:0] tag_ff [SLOTS];
   logic [SLOTS-1:0]    valid_ff;
   logic [SLOTS-1:0]    acc_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   rcc_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // truncation to the file end
   logic [48:0] diff;
   logic [15:0] trunc_len;
   assign diff = {1'b0, backing_size_ff} - {1'b0, off_ff};
   always_comb begin
      if (diff[47:16] == 32'd0 && diff[15:0] < len_ff) begin
         trunc_len = diff[15:0];
      end else begin
         trunc_len = len_ff;
      end
   end

   // parallel tag match
   logic [TAG_BITS-1:0]  cur_tag;
   logic [SLOTS-1:0]     match;
   logic [SLOT_BITS-1:0] match_idx;
   assign cur_tag = off_ff[OFFSET_BITS-1:REGION_SHIFT];
   always_comb begin
      match_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (tag_ff[i] == cur_tag);
         if (match[i]) begin
            match_idx = SLOT_BITS'(i);
         end
      end
   end

   // clock hand step
   logic [SLOT_BITS-1:0] hand_next;
   logic                 victim;
   assign hand_next = (hand_ff == SLOT_BITS'(SLOTS - 1)) ? '0 : hand_ff + 1'b1;
   assign victim    = !valid_ff[hand_next] || !acc_ff[hand_next];

   // chunk sizing
   logic [11:0] boff;
   logic [12:0] room;
   logic [12:0] bsize;
   logic [15:0] len_left;
   logic        last;
   assign boff = off_ff[REGION_SHIFT-1:0];
   assign room = 13'(REGION_SIZE) - {1'b0, boff};
   always_comb begin
      if (len_ff < {3'b000, room}) begin
         bsize = len_ff[12:0];
      end else begin
         bsize = room;
      end
   end
   assign len_left = len_ff - {3'b000, bsize};
   assign last     = (len_left == 16'd0) || (count_ff == COUNT_BITS'(MAX_RESULTS - 1));

   logic out_busy;
   logic rsp_load;
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_load = !out_busy && (ctrl.op == OP_CHUNK || ctrl.op == OP_BEYOND);

   assign flags.fire     = req_valid;
   assign flags.beyond   = diff[48];
   assign flags.hit      = |match;
   assign flags.victim   = victim;
   assign flags.out_busy = out_busy;
   assign flags.more     = !last_ff;

   assign req_stall = !ctrl.idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         backing_size_ff <= '0;
      end else if (csr_write_enable) begin
         backing_size_ff <= csr_write_data;
      end
   end

   // control state: slot bookkeeping, hand and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         acc_ff       <= '0;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctrl.op == OP_SWEEP) begin
            hand_ff <= hand_next;
            if (victim) begin
               valid_ff[hand_next] <= 1'b1;
            end else begin
               acc_ff[hand_next] <= 1'b0;
            end
         end
         if (ctrl.op == OP_CHUNK && !out_busy) begin
            acc_ff[slot_ff] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (ctrl.op) inside
         OP_LOAD: begin
            if (req_valid) begin
               off_ff   <= req_data.read_offset;
               len_ff   <= req_data.read_length;
               dest_ff  <= '0;
               count_ff <= '0;
            end
         end
         OP_TRUNC: begin
            len_ff   <= trunc_len;
            total_ff <= trunc_len;
         end
         OP_MATCH: begin
            slot_ff  <= match_idx;
            hit_ff   <= |match;
            evict_ff <= 1'b0;
         end
         OP_SWEEP: begin
            if (victim) begin
               tag_ff[hand_next] <= cur_tag;
               slot_ff           <= hand_next;
               evict_ff          <= valid_ff[hand_next];
            end
         end
         OP_CHUNK: begin
            if (!out_busy) begin
               off_ff   <= off_ff + {35'd0, bsize};
               dest_ff  <= dest_ff + {3'b000, bsize};
               len_ff   <= len_left;
               count_ff <= count_ff + 1'b1;
               last_ff  <= last;
            end
         end
         OP_NOP, OP_BEYOND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (ctrl.op == OP_BEYOND) begin
            rsp_data_ff.slot          <= '0;
            rsp_data_ff.hit           <= 1'b0;
            rsp_data_ff.evicted       <= 1'b0;
            rsp_data_ff.region_start  <= '0;
            rsp_data_ff.buffer_offset <= '0;
            rsp_data_ff.chunk_length  <= '0;
            rsp_data_ff.dest_offset   <= '0;
            rsp_data_ff.total_length  <= '0;
            rsp_data_ff.beyond_end    <= 1'b1;
            rsp_data_ff.last_chunk    <= 1'b1;
         end else begin
            rsp_data_ff.slot          <= 3'(slot_ff);
            rsp_data_ff.hit           <= hit_ff;
            rsp_data_ff.evicted       <= evict_ff;
            rsp_data_ff.region_start  <= {cur_tag, {REGION_SHIFT{1'b0}}};
            rsp_data_ff.buffer_offset <= boff;
            rsp_data_ff.chunk_length  <= bsize;
            rsp_data_ff.dest_offset   <= dest_ff;
            rsp_data_ff.total_length  <= total_ff;
            rsp_data_ff.beyond_end    <= 1'b0;
            rsp_data_ff.last_chunk    <= last;
         end
      end
   end

endmodule

### rtl/rcc_sequencer.sv
// microcode sequencer: step counter, control rom and conditional jumps
module rcc_sequencer
   import rcc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   localparam logic [2:0] C_ALWAYS   = 3'd0;
   localparam logic [2:0] C_NOFIRE   = 3'd1;
   localparam logic [2:0] C_BEYOND   = 3'd2;
   localparam logic [2:0] C_HIT      = 3'd3;
   localparam logic [2:0] C_NOVICTIM = 3'd4;
   localparam logic [2:0] C_OUTBUSY  = 3'd5;
   localparam logic [2:0] C_MORE     = 3'd6;

   localparam logic [3:0] ST_WAIT   = 4'd0;
   localparam logic [3:0] ST_TRUNC  = 4'd1;
   localparam logic [3:0] ST_MATCH  = 4'd2;
   localparam logic [3:0] ST_SWEEP  = 4'd3;
   localparam logic [3:0] ST_CHUNK  = 4'd4;
   localparam logic [3:0] ST_NEXT   = 4'd5;
   localparam logic [3:0] ST_DONE   = 4'd6;
   localparam logic [3:0] ST_BEYOND = 4'd7;
   localparam logic [3:0] ST_BDONE  = 4'd8;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] cond;
      logic [3:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [3:0] step);
      ucode_type w;
      unique case (step)
         ST_WAIT:   w = '{op: OP_LOAD,   cond: C_NOFIRE,   target: ST_WAIT};
         ST_TRUNC:  w = '{op: OP_TRUNC,  cond: C_BEYOND,   target: ST_BEYOND};
         ST_MATCH:  w = '{op: OP_MATCH,  cond: C_HIT,      target: ST_CHUNK};
         ST_SWEEP:  w = '{op: OP_SWEEP,  cond: C_NOVICTIM, target: ST_SWEEP};
         ST_CHUNK:  w = '{op: OP_CHUNK,  cond: C_OUTBUSY,  target: ST_CHUNK};
         ST_NEXT:   w = '{op: OP_NOP,    cond: C_MORE,     target: ST_MATCH};
         ST_DONE:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_WAIT};
         ST_BEYOND: w = '{op: OP_BEYOND, cond: C_OUTBUSY,  target: ST_BEYOND};
         ST_BDONE:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_WAIT};
         default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_WAIT};
      endcase
      return w;
   endfunction

   logic [3:0] step_ff, step_in;
   ucode_type  word;
   logic       take;

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         C_ALWAYS:   take = 1'b1;
         C_NOFIRE:   take = !flags.fire;
         C_BEYOND:   take = flags.beyond;
         C_HIT:      take = flags.hit;
         C_NOVICTIM: take = !flags.victim;
         C_OUTBUSY:  take = flags.out_busy;
         C_MORE:     take = flags.more;
         default:    take = 1'b1;
      endcase
      step_in = take ? word.target : step_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.idle = (step_ff == ST_WAIT);

endmodule
